// ===== rtl/core/rpmd_pkg.sv =====
package rpmd_pkg;

   // Frame store size in pixels
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_SCALE  = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_LOAD_WAIT,
      ST_SCAN,
      ST_MULT,
      ST_GROW,
      ST_NEXT_LINE,
      ST_READ_WAIT,
      ST_RSP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic mem_write;     // host pixel write
      logic mem_read;      // host pixel read
      logic start_run;     // latch sizes, zero line counters
      logic load_issue;    // read frame pixel at load index
      logic load_take;     // store registered pixel into line buffer
      logic scan_step;     // advance scan index
      logic run_close;     // run ended: latch end, compute product
      logic grow_setup;    // compute lo/hi from product
      logic grow_step;     // set frame pixel at grow index
      logic next_line;     // advance line / pass
      logic rsp_load;      // capture read data into output register
   } cmd_bus_type;

   // Datapath to controller
   typedef struct packed {
      logic run_empty;     // scale zero or empty area
      logic load_last;     // load index at line end
      logic scan_done;     // scan index past line end
      logic scan_set;      // pixel at scan index set
      logic run_open;      // inside a run
      logic grow_last;     // grow index at hi
      logic all_done;      // last line of column pass
   } sts_bus_type;

endpackage

// ===== rtl/core/rpmd_ctrl.sv =====
module rpmd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output rpmd_pkg::cmd_bus_type cmd_bus,
   input  rpmd_pkg::sts_bus_type sts_bus
);
   import rpmd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Hold state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Sequence host accesses and the two dilation passes
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_bus      = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_cmd)
                  CMD_WRITE: cmd_bus.mem_write = 1'b1;
                  CMD_RUN: begin
                     cmd_bus.start_run = 1'b1;
                     state_in = ST_NEXT_LINE;
                  end
                  CMD_READ: begin
                     cmd_bus.mem_read = 1'b1;
                     state_in = ST_READ_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ_WAIT: begin
            // output register busy: wait until it frees up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd_bus.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_NEXT_LINE: begin
            // entered after start and after each line scan: datapath decides empty, done or next line
            if (sts_bus.run_empty || sts_bus.all_done) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_LOAD;
            end
            cmd_bus.next_line = 1'b1;
         end
         ST_LOAD: begin
            cmd_bus.load_issue = 1'b1;
            state_in = ST_LOAD_WAIT;
         end
         ST_LOAD_WAIT: begin
            cmd_bus.load_take = 1'b1;
            if (sts_bus.load_last) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_SCAN: begin
            if (sts_bus.run_open && (sts_bus.scan_done || !sts_bus.scan_set)) begin
               cmd_bus.run_close = 1'b1;
               state_in = ST_MULT;
            end else if (sts_bus.scan_done) begin
               state_in = ST_NEXT_LINE;
            end else begin
               cmd_bus.scan_step = 1'b1;
            end
         end
         ST_MULT: begin
            cmd_bus.grow_setup = 1'b1;
            state_in = ST_GROW;
         end
         ST_GROW: begin
            cmd_bus.grow_step = 1'b1;
            if (sts_bus.grow_last) begin
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/rpmd_datapath.sv =====
module rpmd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_col_index,
   input  logic [7:0]            req_row_index,
   input  logic                  req_pixel_in,
   input  logic [11:0]           scale_ff,
   input  logic [8:0]            width_ff,
   input  logic [8:0]            height_ff,
   output logic                  rsp_pixel_out,
   input  rpmd_pkg::cmd_bus_type cmd_bus,
   output rpmd_pkg::sts_bus_type sts_bus
);
   import rpmd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int LD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int LW = $clog2(LD);
   localparam int NW = LW + 1;
   localparam int PW = 12 + NW;

   logic frame_mem [MAX_WIDTH*MAX_HEIGHT];
   logic line_mem  [LD];

   logic          rd_data_ff;
   logic          rd_inside_ff;
   logic          pix_out_ff;
   logic          pass_ff;          // 0 row pass, 1 column pass
   logic          first_ff;         // next_line before first line
   logic [NW-1:0] line_ff;          // current line index
   logic [NW-1:0] w_ff, h_ff;
   logic [NW-1:0] ld_ff;            // load index
   logic [NW-1:0] sc_ff;            // scan index
   logic [NW-1:0] beg_ff, end_ff;
   logic          open_ff;
   logic [PW-1:0] prod_ff;
   logic [NW-1:0] gi_ff, hi_ff;
   logic          empty_ff;

   logic [NW-1:0] n_len;
   logic [NW-1:0] nlines;
   logic [CW+RW-1:0] host_addr;
   logic          host_inside;
   logic [NW-1:0] ln;
   logic [NW-1:0] pos;
   logic [CW+RW-1:0] line_addr;
   logic          scan_pix;
   logic [LW-1:0] scan_idx;
   logic [PW-1:0] left_g, right_g;
   logic [NW-1:0] lo_v, hi_v;

   assign n_len  = pass_ff ? h_ff : w_ff;
   assign nlines = pass_ff ? w_ff : h_ff;
   assign host_inside = (32'(req_col_index) < MAX_WIDTH) &&
                        (32'(req_row_index) < MAX_HEIGHT);
   assign host_addr = {req_row_index[RW-1:0], req_col_index[CW-1:0]};
   assign ln = line_ff;

   // Frame address of position pos in the current line
   always_comb begin
      if (cmd_bus.grow_step) begin
         pos = gi_ff;
      end else begin
         pos = ld_ff;
      end
      if (pass_ff) begin
         line_addr = {pos[RW-1:0], ln[CW-1:0]};
      end else begin
         line_addr = {ln[RW-1:0], pos[CW-1:0]};
      end
   end

   // Frame store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd_bus.mem_write && host_inside) begin
         frame_mem[host_addr] <= req_pixel_in;
      end
      if (cmd_bus.grow_step) begin
         frame_mem[line_addr] <= 1'b1;
      end
      if (cmd_bus.mem_read) begin
         rd_data_ff <= frame_mem[host_addr];
      end else if (cmd_bus.load_issue) begin
         rd_data_ff <= frame_mem[line_addr];
      end
   end

   assign scan_idx = sc_ff[LW-1:0] + ((cmd_bus.scan_step && !sts_bus.scan_done) ?
                     LW'(1) : LW'(0));

   // Line buffer: snapshot of the line before growth
   always_ff @(posedge clock) begin
      if (cmd_bus.load_take) begin
         line_mem[ld_ff[LW-1:0]] <= rd_data_ff;
      end
      // forward a word written at the address being read
      if (cmd_bus.load_take && (ld_ff[LW-1:0] == scan_idx)) begin
         scan_pix <= rd_data_ff;
      end else begin
         scan_pix <= line_mem[scan_idx];
      end
   end

   // Growth amounts, halves down on the left and up on the right
   assign left_g  = (prod_ff + PW'(255)) >> 9;
   assign right_g = (prod_ff + PW'(256)) >> 9;
   always_comb begin
      lo_v = (PW'(beg_ff) > left_g) ? beg_ff - NW'(left_g) : '0;
      hi_v = (right_g > PW'(n_len - NW'(1) - end_ff)) ? n_len - NW'(1)
             : end_ff + NW'(right_g);
   end

   // Line walk control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff  <= 1'b0;
         first_ff <= 1'b0;
         open_ff  <= 1'b0;
         empty_ff <= 1'b0;
         line_ff  <= '0;
      end else begin
         if (cmd_bus.start_run) begin
            w_ff     <= (32'(width_ff) > MAX_WIDTH) ? NW'(MAX_WIDTH) : NW'(width_ff);
            h_ff     <= (32'(height_ff) > MAX_HEIGHT) ? NW'(MAX_HEIGHT) : NW'(height_ff);
            empty_ff <= (scale_ff == '0) || (width_ff == '0) || (height_ff == '0);
            pass_ff  <= 1'b0;
            first_ff <= 1'b1;
            line_ff  <= '0;
         end
         if (cmd_bus.next_line) begin
            first_ff <= 1'b0;
            ld_ff    <= '0;
            sc_ff    <= '0;
            open_ff  <= 1'b0;
            if (!first_ff) begin
               if (line_ff == nlines - NW'(1)) begin
                  pass_ff <= 1'b1;
                  line_ff <= '0;
               end else begin
                  line_ff <= line_ff + NW'(1);
               end
            end
         end
         if (cmd_bus.load_take) begin
            ld_ff <= ld_ff + NW'(1);
         end
         if (cmd_bus.scan_step) begin
            if (scan_pix && !open_ff) begin
               open_ff <= 1'b1;
               beg_ff  <= sc_ff;
            end
            sc_ff <= sc_ff + NW'(1);
         end
         if (cmd_bus.run_close) begin
            open_ff <= 1'b0;
            end_ff  <= sc_ff - NW'(1);
            prod_ff <= PW'(scale_ff) * PW'(sc_ff - beg_ff);
         end
         if (cmd_bus.grow_setup) begin
            gi_ff <= lo_v;
            hi_ff <= hi_v;
         end
         if (cmd_bus.grow_step) begin
            gi_ff <= gi_ff + NW'(1);
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd_bus.mem_read) begin
         rd_inside_ff <= host_inside;
      end
      if (cmd_bus.rsp_load) begin
         pix_out_ff <= rd_inside_ff & rd_data_ff;
      end
   end

   assign rsp_pixel_out = pix_out_ff;

   always_comb begin
      sts_bus.run_empty = empty_ff;
      sts_bus.load_last = (ld_ff == n_len - NW'(1));
      sts_bus.scan_done = (sc_ff == n_len);
      sts_bus.scan_set  = scan_pix;
      sts_bus.run_open  = open_ff;
      sts_bus.grow_last = (gi_ff == hi_ff);
      sts_bus.all_done  = !first_ff && pass_ff && (line_ff == nlines - NW'(1));
   end

endmodule

// ===== rtl/core/run_proportional_mask_dilation.sv =====
// Channel | Direction | Ports
// req     | in        | req_valid, req_ready, req_cmd, req_col_index, req_row_index, req_pixel_in
// rsp     | out       | rsp_valid, rsp_ready, rsp_pixel_out
// csr     | in        | csr_valid, csr_ready, csr_index, csr_data
// A pixel write is stored when it is taken; a read's word reaches rsp through the read
// data register and then the output register. A run loads, scans and grows each line,
// one grown span per run found, over height_used rows then width_used columns.
// A run with zero scale or an empty area returns to idle without loading a line.
// Reset clears control state and sets scale 0, size 256 by 256; frame contents stay unknown until written.
// A read waits while the output register still holds an untaken word.
module run_proportional_mask_dilation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_col_index,
   input  logic [7:0]  req_row_index,
   input  logic        req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pixel_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);
   import rpmd_pkg::*;

   logic [11:0] scale_ff;
   logic [8:0]  width_ff, height_ff;
   cmd_bus_type cmd_bus;
   sts_bus_type sts_bus;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= '0;
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCALE:  scale_ff  <= csr_data;
            CSR_WIDTH:  width_ff  <= csr_data[8:0];
            CSR_HEIGHT: height_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   rpmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .cmd_bus   (cmd_bus),
      .sts_bus   (sts_bus)
   );

   rpmd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_col_index (req_col_index),
      .req_row_index (req_row_index),
      .req_pixel_in  (req_pixel_in),
      .scale_ff      (scale_ff),
      .width_ff      (width_ff),
      .height_ff     (height_ff),
      .rsp_pixel_out (rsp_pixel_out),
      .cmd_bus       (cmd_bus),
      .sts_bus       (sts_bus)
   );

endmodule

// ===== sim/dilation_checker.sv =====
`timescale 1ns / 1ps

module dilation_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_col_index,
   input  logic [7:0]  req_row_index,
   input  logic        req_pixel_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_pixel_out,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data,
   output int          fail_count,
   output int          reads_due
);
   import rpmd_pkg::*;

   bit          frame_bits [0:65535];
   bit          line_copy [0:255];
   logic [11:0] scale_q;
   logic [8:0]  width_q;
   logic [8:0]  height_q;
   bit          read_bits_due [$];

   initial fail_count = 0;
   initial reads_due = 0;

   // Grow every run of one line, measured on the line before this pass
   function automatic void dilate_line(int base, int stride, int n, int s);
      int k;
      int b;
      int e;
      int prod;
      int left;
      int right;
      int lo;
      int hi;
      for (k = 0; k < n; k++) line_copy[k] = frame_bits[base + k * stride];
      k = 0;
      while (k < n) begin
         if (!line_copy[k]) begin
            k++;
         end else begin
            b = k;
            while (k < n && line_copy[k]) k++;
            e = k - 1;
            prod = s * (e - b + 1);
            left = (prod + 255) >> 9;
            right = (prod + 256) >> 9;
            lo = (b > left) ? b - left : 0;
            hi = (right > (n - 1) - e) ? n - 1 : e + right;
            for (int p = lo; p <= hi; p++) frame_bits[base + p * stride] = 1'b1;
         end
      end
   endfunction

   // Rows first, then columns of the row-grown frame
   function automatic void dilate_frame();
      int w;
      int h;
      w = (width_q > 256) ? 256 : width_q;
      h = (height_q > 256) ? 256 : height_q;
      if (scale_q == 0 || w == 0 || h == 0) return;
      for (int r = 0; r < h; r++) dilate_line(r * 256, 1, w, scale_q);
      for (int c = 0; c < w; c++) dilate_line(c, 256, h, scale_q);
   endfunction

   // Sample handshakes mid-cycle; they complete at the next rising edge
   always @(negedge clock) begin
      bit want;
      if (reset) begin
         scale_q = 12'd0;
         width_q = 9'd256;
         height_q = 9'd256;
         read_bits_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCALE:  scale_q = csr_data;
               CSR_WIDTH:  width_q = csr_data[8:0];
               CSR_HEIGHT: height_q = csr_data[8:0];
               default: ;
            endcase
         end
         // check returned word against oldest pending read
         if (rsp_valid && rsp_ready) begin
            if (read_bits_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, actual %0b",
                        $time, rsp_pixel_out);
            end else begin
               want = read_bits_due.pop_front();
               if (rsp_pixel_out !== want) begin
                  fail_count++;
                  $display("%0t: pixel_out mismatch, expected %0b, actual %0b",
                           $time, want, rsp_pixel_out);
               end
            end
         end
         if (req_valid && req_ready) begin
            case (cmd_type'(req_cmd))
               CMD_WRITE: frame_bits[{req_row_index, req_col_index}] = req_pixel_in;
               CMD_RUN:   dilate_frame();
               CMD_READ:  read_bits_due.push_back(frame_bits[{req_row_index, req_col_index}]);
               default: ;
            endcase
         end
      end
      reads_due = read_bits_due.size();
   end

endmodule

// ===== sim/run_proportional_mask_dilation_test.sv =====
`timescale 1ns / 1ps

module run_proportional_mask_dilation_test;
   import rpmd_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_NONE;
   logic [7:0]  req_col_index = 8'd0;
   logic [7:0]  req_row_index = 8'd0;
   logic        req_pixel_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_pixel_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SCALE;
   logic [11:0] csr_data = 12'd0;
   int          fail_count;
   int          reads_due;

   bit          written_map [0:65535];
   int          burst_left = 0;
   int          area_w = 256;
   int          area_h = 256;
   int          num_writes = 0;
   int          num_reads = 0;
   int          num_runs = 0;
   int          num_settings = 0;
   int          cycle_count = 0;
   logic [7:0]  stall_tick = 8'd0;
   int          stall_mode = 0;

   run_proportional_mask_dilation uut (.*);

   dilation_checker checker_i (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Receiver stalls: mode is redrawn whenever stall_tick wraps to zero
   always @(posedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick == 8'd0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= (stall_tick[4:3] != 2'd0);
      endcase
   end

   // Hard stop on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Send one word; gaps fall between random bursts
   task automatic send_word(cmd_type c, logic [7:0] col, logic [7:0] row, logic pix);
      bit took;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_col_index <= col;
      req_row_index <= row;
      req_pixel_in <= pix;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      burst_left--;
      case (c)
         CMD_WRITE: begin
            written_map[{row, col}] = 1'b1;
            num_writes++;
         end
         CMD_READ: num_reads++;
         CMD_RUN:  num_runs++;
         default: ;
      endcase
   endtask

   task automatic csr_write(logic [1:0] idx, logic [11:0] value);
      bit took;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
   endtask

   // Drain reads and let any run finish walking the frame
   task automatic wait_idle();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (reads_due != 0 || !req_ready);
      @(posedge clock);
   endtask

   task automatic configure(int scale, int w, int h);
      wait_idle();
      csr_write(CSR_SCALE, 12'(scale));
      csr_write(CSR_WIDTH, 12'(w));
      csr_write(CSR_HEIGHT, 12'(h));
      csr_valid <= 1'b0;
      area_w = (w > 256) ? 256 : w;
      area_h = (h > 256) ? 256 : h;
      num_settings++;
   endtask

   // One setting: fill the used area, then a random mix
   task automatic run_phase(int scale, int w, int h, int count);
      int density;
      int roll;
      logic [7:0] col;
      logic [7:0] row;
      density = $urandom_range(10, 60);
      configure(scale, w, h);
      for (int r = 0; r < area_h; r++)
         for (int c = 0; c < area_w; c++)
            if (!written_map[{r[7:0], c[7:0]}])
               send_word(CMD_WRITE, c[7:0], r[7:0], $urandom_range(0, 99) < density);
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (area_w > 0 && area_h > 0 && $urandom_range(0, 3) != 0) begin
            col = 8'($urandom_range(0, area_w - 1));
            row = 8'($urandom_range(0, area_h - 1));
         end else begin
            col = 8'($urandom_range(0, 255));
            row = 8'($urandom_range(0, 255));
         end
         if (roll < 40)
            send_word(CMD_WRITE, col, row, $urandom_range(0, 99) < density);
         else if (roll < 78) begin
            // never read a pixel that was not written
            if (written_map[{row, col}])
               send_word(CMD_READ, col, row, 1'($urandom_range(0, 1)));
            else
               send_word(CMD_WRITE, col, row, $urandom_range(0, 99) < density);
         end else if (roll < 88)
            send_word(CMD_RUN, col, row, 1'($urandom_range(0, 1)));
         else
            send_word(CMD_NONE, col, row, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      bit pattern [0:2][0:5];
      pattern = '{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1},
                  '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
                  '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: runs at both edges, a short run, field extremes
      configure(256, 6, 3);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 6; c++)
            send_word(CMD_WRITE, c[7:0], r[7:0], pattern[r][c]);
      send_word(CMD_WRITE, 8'd255, 8'd255, 1'b1);
      send_word(CMD_NONE, 8'd255, 8'd255, 1'b1);
      send_word(CMD_RUN, 8'd0, 8'd0, 1'b0);
      send_word(CMD_READ, 8'd255, 8'd255, 1'b0);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 6; c++)
            send_word(CMD_READ, c[7:0], r[7:0], 1'b1);

      // Random settings, sizes at both extremes and saturating
      run_phase(4095, 16, 16, 40);
      run_phase(0, 16, 16, 20);
      run_phase(1, 12, 10, 30);
      run_phase(128, 10, 8, 30);
      run_phase(384, 20, 6, 30);
      run_phase(700, 300, 1, 30);
      run_phase(2000, 1, 256, 20);
      run_phase(300, 0, 5, 10);
      run_phase(255, 8, 0, 10);
      run_phase(4095, 256, 2, 20);
      run_phase(511, 9, 9, 40);

      wait_idle();
      $display("covered %0d pixel writes, %0d reads and %0d dilation runs",
               num_writes, num_reads, num_runs);
      $display("over %0d register settings, scale 0 to 4095, sizes 0 to 300",
               num_settings);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rpmd_pkg.sv
rtl/core/rpmd_ctrl.sv
rtl/core/rpmd_datapath.sv
rtl/core/run_proportional_mask_dilation.sv
sim/dilation_checker.sv
sim/run_proportional_mask_dilation_test.sv
